>>> src/a64alu_pkg.sv
// Shared types, opcodes and condition evaluation for the ARM64 subset ALU.
package a64alu_pkg;

  localparam int unsigned DataWidth   = 64;
  localparam int unsigned FuncWidth   = 5;
  localparam int unsigned ShiftWidth  = 6;
  localparam int unsigned FlagWidth   = 4;
  localparam int unsigned CondWidth   = 4;
  localparam int unsigned InDataWidth  = 144;  // 143 bits of fields, padded to bytes
  localparam int unsigned OutDataWidth = 72;   // 69 bits of fields, padded to bytes

  localparam logic [DataWidth-1:0] Mask16 = 64'h0000_0000_0000_FFFF;

  // NZCV bit positions
  localparam int unsigned FlagN = 3;
  localparam int unsigned FlagZ = 2;
  localparam int unsigned FlagC = 1;
  localparam int unsigned FlagV = 0;

  typedef enum logic [FuncWidth-1:0] {
    OP_ADD   = 5'd0,
    OP_SUB   = 5'd1,
    OP_ORN   = 5'd2,
    OP_ORR   = 5'd3,
    OP_EOR   = 5'd4,
    OP_AND   = 5'd5,
    OP_MOVZ  = 5'd6,
    OP_MOVK  = 5'd7,
    OP_LSL   = 5'd8,
    OP_LSR   = 5'd9,
    OP_ASR   = 5'd10,
    OP_PASS  = 5'd11,
    OP_CSEL  = 5'd12,
    OP_CSINV = 5'd13,
    OP_CSINC = 5'd14,
    OP_CSNEG = 5'd15,
    OP_CBZ   = 5'd16,
    OP_CBNZ  = 5'd17
  } op_t;

  typedef enum logic [CondWidth-1:0] {
    COND_EQ = 4'd0,
    COND_NE = 4'd1,
    COND_CS = 4'd2,
    COND_CC = 4'd3,
    COND_MI = 4'd4,
    COND_PL = 4'd5,
    COND_VS = 4'd6,
    COND_VC = 4'd7,
    COND_HI = 4'd8,
    COND_LS = 4'd9,
    COND_GE = 4'd10,
    COND_LT = 4'd11,
    COND_GT = 4'd12,
    COND_LE = 4'd13,
    COND_AL = 4'd14,
    COND_NV = 4'd15
  } cond_t;

  typedef struct packed {
    logic [FuncWidth-1:0]  func;
    logic [DataWidth-1:0]  operand_a;
    logic [DataWidth-1:0]  operand_b;
    logic [ShiftWidth-1:0] halfword_shift;
    logic [FlagWidth-1:0]  flags_in;
    logic                  update_flags;
    logic [CondWidth-1:0]  condition;
  } alu_req_t;

  typedef struct packed {
    logic [DataWidth-1:0] result;
    logic [FlagWidth-1:0] flags_out;
    logic                 cond_true;
  } alu_rsp_t;

  function automatic logic cond_pass(logic [CondWidth-1:0] cond, logic [FlagWidth-1:0] f);
    logic n;
    logic z;
    logic c;
    logic v;
    logic h;
    n = f[FlagN];
    z = f[FlagZ];
    c = f[FlagC];
    v = f[FlagV];
    unique case (cond_t'(cond))
      COND_EQ: h = z;
      COND_NE: h = !z;
      COND_CS: h = c;
      COND_CC: h = !c;
      COND_MI: h = n;
      COND_PL: h = !n;
      COND_VS: h = v;
      COND_VC: h = !v;
      COND_HI: h = c && !z;
      COND_LS: h = !c || z;
      COND_GE: h = (n == v);
      COND_LT: h = (n != v);
      COND_GT: h = !z && (n == v);
      COND_LE: h = z || (n != v);
      default: h = 1'b1;  // AL and NV
    endcase
    return h;
  endfunction

endpackage

>>> src/a64alu_exec.sv
// Combinational execute logic: result, NZCV update and condition check.
module a64alu_exec (
  input  a64alu_pkg::alu_req_t req,
  output a64alu_pkg::alu_rsp_t rsp
);
  import a64alu_pkg::*;

  logic [DataWidth-1:0] a;
  logic [DataWidth-1:0] b;
  logic [DataWidth-1:0] b_add;
  logic [DataWidth:0]   sum;
  logic                 is_sub;
  logic                 holds_in;
  logic [DataWidth-1:0] cs_base;
  logic [DataWidth-1:0] cs_alt;
  logic [DataWidth-1:0] b_moved;
  logic [ShiftWidth-1:0] sh;
  logic [DataWidth-1:0] r;
  logic                 arith;
  logic                 logic_op;
  logic                 ovf;
  logic [FlagWidth-1:0] nf;

  assign a      = req.operand_a;
  assign b      = req.operand_b;
  assign sh     = b[ShiftWidth-1:0];
  assign is_sub = (req.func == OP_SUB);
  // sub is a + ~b + 1
  assign b_add  = is_sub ? ~b : b;
  assign sum    = {1'b0, a} + {1'b0, b_add} + {{DataWidth{1'b0}}, is_sub};
  assign ovf    = (a[DataWidth-1] == b_add[DataWidth-1]) &&
                  (sum[DataWidth-1] != a[DataWidth-1]);

  assign holds_in = cond_pass(req.condition, req.flags_in);
  // one incrementer serves csinc (b+1) and csneg (~b+1)
  assign cs_base  = ((req.func == OP_CSINV) || (req.func == OP_CSNEG)) ? ~b : b;
  assign cs_alt   = cs_base + {{(DataWidth-1){1'b0}},
                               ((req.func == OP_CSINC) || (req.func == OP_CSNEG))};
  assign b_moved  = b << req.halfword_shift;

  always_comb begin
    r        = '0;
    arith    = 1'b0;
    logic_op = 1'b0;
    unique case (op_t'(req.func))
      OP_ADD, OP_SUB: begin
        r     = sum[DataWidth-1:0];
        arith = 1'b1;
      end
      OP_ORN: begin
        r        = a | ~b;
        logic_op = 1'b1;
      end
      OP_ORR: begin
        r        = a | b;
        logic_op = 1'b1;
      end
      OP_EOR: begin
        r        = a ^ b;
        logic_op = 1'b1;
      end
      OP_AND: begin
        r        = a & b;
        logic_op = 1'b1;
      end
      OP_MOVZ:  r = a | b_moved;
      OP_MOVK:  r = (a & ~(Mask16 << req.halfword_shift)) | b_moved;
      OP_LSL:   r = a << sh;
      OP_LSR:   r = a >> sh;
      OP_ASR:   r = DataWidth'($signed(a) >>> sh);
      OP_PASS, OP_CBZ, OP_CBNZ: r = a;
      OP_CSEL:  r = holds_in ? a : b;
      OP_CSINV, OP_CSINC, OP_CSNEG: r = holds_in ? a : cs_alt;
      default:  r = '0;
    endcase
  end

  always_comb begin
    nf = req.flags_in;
    if (req.update_flags && arith) begin
      nf = {r[DataWidth-1], (r == '0), sum[DataWidth], ovf};
    end else if (req.update_flags && logic_op) begin
      nf = {r[DataWidth-1], (r == '0), 1'b0, 1'b0};
    end
  end

  assign rsp.result    = r;
  assign rsp.flags_out = nf;
  assign rsp.cond_true = cond_pass(req.condition, nf);

endmodule

>>> src/arm64_subset_alu_nzcv_top.sv
// Top level: input register, execute logic and result register with stream handshakes.
// A request is held in the input register, then its result in the register on m_tdata.
// Throughput: one request per cycle without back-pressure; input and result registers
// form a two-entry pipeline; a waiting result still lets an empty input register fill.
// Reset: rst, synchronous, active high, empties both pipeline registers.
module arm64_subset_alu_nzcv_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // operand_a[63:0], operand_b[127:64], halfword_shift[133:128], flags_in[137:134],
  // update_flags[138], condition[142:139], zero pad [143]
  input  logic [a64alu_pkg::InDataWidth-1:0]  s_tdata,
  // func[4:0]
  input  logic [a64alu_pkg::FuncWidth-1:0]    s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // result[63:0], flags_out[67:64], cond_true[68], zero pad [71:69]
  output logic [a64alu_pkg::OutDataWidth-1:0] m_tdata
);
  import a64alu_pkg::*;

  logic     s1_valid;
  alu_req_t s1_req;
  logic     out_valid;
  alu_rsp_t out_rsp;
  alu_rsp_t exec_rsp;
  logic     s1_ready;
  logic     out_ready;

  assign out_ready = !out_valid || m_tready;
  assign s1_ready  = !s1_valid || out_ready;
  assign s_tready  = s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s1_ready) begin
      s1_req.func           <= s_tuser;
      s1_req.operand_a      <= s_tdata[63:0];
      s1_req.operand_b      <= s_tdata[127:64];
      s1_req.halfword_shift <= s_tdata[133:128];
      s1_req.flags_in       <= s_tdata[137:134];
      s1_req.update_flags   <= s_tdata[138];
      s1_req.condition      <= s_tdata[142:139];
    end
  end

  a64alu_exec u_exec (
    .req (s1_req),
    .rsp (exec_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && out_ready) begin
      out_rsp <= exec_rsp;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {3'b000, out_rsp.cond_true, out_rsp.flags_out, out_rsp.result};

`ifndef SYNTHESIS
  a_s1_moves: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && out_ready) |=> m_tvalid)
    else $error("request in input register did not reach result register");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    (!s1_valid && !m_tvalid) |=> !m_tvalid)
    else $error("result appeared without a request");

  a_flags_kept: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_req.update_flags) |-> (exec_rsp.flags_out == s1_req.flags_in))
    else $error("flags changed without update_flags");

  a_unknown_zero: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && (s1_req.func > OP_CBNZ)) |-> (exec_rsp.result == '0))
    else $error("unknown operation gave a nonzero result");
`endif

endmodule
